FILE: hdl/knl_pkg.sv
// Shared types and constants for the k-nearest candidate list.
package knl_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int LEN_W     = 5;
   localparam int ID_W      = 24;
   localparam int DIST_W    = 32;
   localparam int POS_W     = 4;
   localparam int K_W       = $clog2(MAX_SLOTS + 1);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam logic [LEN_W-1:0] LIST_LENGTH_RESET = LEN_W'(16);

   typedef enum logic {
      ST_EMPTY,
      ST_HELD
   } ctrl_state_type;

   typedef struct packed {
      logic exec_item;
   } ctrl_cmd_type;

endpackage

FILE: hdl/knl_ctrl.sv
// Handshake controller: tracks the result register and issues execute commands.
module knl_ctrl
   import knl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid     = 1'b0;
      req_stall     = 1'b0;
      cmd.exec_item = 1'b0;
      case (state_ff)
         ST_EMPTY: begin
            if (req_valid) begin
               cmd.exec_item = 1'b1;
               state_in      = ST_HELD;
            end
         end
         ST_HELD: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            if (!rsp_stall) begin
               // The result leaves this cycle, so a new item may replace it.
               if (req_valid) begin
                  cmd.exec_item = 1'b1;
               end else begin
                  state_in = ST_EMPTY;
               end
            end
         end
         default: begin
            state_in = ST_EMPTY;
         end
      endcase
   end

endmodule

FILE: hdl/knl_datapath.sv
// Candidate list registers, parallel compare and shift network, result register.
module knl_datapath
   import knl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data,
   input  logic              req_kind,
   input  logic [ID_W-1:0]   req_candidate_id,
   input  logic [DIST_W-1:0] req_candidate_distance,
   input  logic [POS_W-1:0]  req_slot,
   output logic [ID_W-1:0]   rsp_out_id,
   output logic [DIST_W-1:0] rsp_out_distance,
   output logic [POS_W-1:0]  rsp_insert_position,
   output logic [DIST_W-1:0] rsp_worst_distance
);

   logic [LEN_W-1:0]  list_length_ff;
   logic [ID_W-1:0]   id_ff   [MAX_SLOTS];
   logic [DIST_W-1:0] dist_ff [MAX_SLOTS];
   logic [ID_W-1:0]   id_in   [MAX_SLOTS];
   logic [DIST_W-1:0] dist_in [MAX_SLOTS];

   logic [ID_W-1:0]   up_id   [MAX_SLOTS];
   logic [DIST_W-1:0] up_dist [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] shift_dn;
   logic [K_W-1:0]    k_eff;

   logic [ID_W-1:0]   out_id_ff,   out_id_in;
   logic [DIST_W-1:0] out_dist_ff, out_dist_in;
   logic [POS_W-1:0]  out_pos_ff,  out_pos_in;
   logic [DIST_W-1:0] worst_ff,    worst_in;

   always_comb begin
      if (list_length_ff == '0) begin
         k_eff = K_W'(1);
      end else if (int'(list_length_ff) > MAX_SLOTS) begin
         k_eff = K_W'(MAX_SLOTS);
      end else begin
         k_eff = K_W'(list_length_ff);
      end
   end

   // Slot i takes entry i+1 when every entry from 1 to i+1 inside k is farther
   // than the candidate.
   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_slot
      if (i < MAX_SLOTS - 1) begin : g_up
         logic gt;
         assign gt = (K_W'(i + 1) < k_eff) && (dist_ff[i + 1] > req_candidate_distance);
         assign up_id[i]   = id_ff[i + 1];
         assign up_dist[i] = dist_ff[i + 1];
         if (i == 0) begin : g_first
            assign shift_dn[i] = gt;
         end else begin : g_rest
            assign shift_dn[i] = shift_dn[i - 1] & gt;
         end
      end else begin : g_top
         assign up_id[i]    = id_ff[i];
         assign up_dist[i]  = dist_ff[i];
         assign shift_dn[i] = 1'b0;
      end
   end

   always_comb begin
      logic [POS_W-1:0] pos;
      logic             fill;
      pos = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (!shift_dn[i]) begin
            pos = POS_W'(i);
         end
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
         id_in[i]   = id_ff[i];
         dist_in[i] = dist_ff[i];
         fill       = (pos == POS_W'(i));
         if (cmd.exec_item && req_kind == KIND_INSERT) begin
            if (shift_dn[i]) begin
               id_in[i]   = up_id[i];
               dist_in[i] = up_dist[i];
            end else if (fill) begin
               id_in[i]   = req_candidate_id;
               dist_in[i] = req_candidate_distance;
            end
         end
      end

      out_id_in   = out_id_ff;
      out_dist_in = out_dist_ff;
      out_pos_in  = out_pos_ff;
      worst_in    = worst_ff;
      if (cmd.exec_item) begin
         if (req_kind == KIND_INSERT) begin
            out_id_in   = id_ff[0];
            out_dist_in = dist_ff[0];
            out_pos_in  = pos;
         end else begin
            out_id_in   = '0;
            out_dist_in = '0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
               if (int'(req_slot) == i) begin
                  out_id_in   = id_ff[i];
                  out_dist_in = dist_ff[i];
               end
            end
            out_pos_in = req_slot;
         end
         worst_in = dist_in[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_length_ff <= LIST_LENGTH_RESET;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            id_ff[i]   <= '0;
            dist_ff[i] <= '1;
         end
      end else begin
         if (csr_wr_en) begin
            list_length_ff <= csr_wr_data;
         end
         for (int i = 0; i < MAX_SLOTS; i++) begin
            id_ff[i]   <= id_in[i];
            dist_ff[i] <= dist_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_id_ff   <= out_id_in;
      out_dist_ff <= out_dist_in;
      out_pos_ff  <= out_pos_in;
      worst_ff    <= worst_in;
   end

   assign rsp_out_id          = out_id_ff;
   assign rsp_out_distance    = out_dist_ff;
   assign rsp_insert_position = out_pos_ff;
   assign rsp_worst_distance  = worst_ff;

endmodule

FILE: hdl/k_nearest_list_insert_core.sv
// Top level of the k-nearest candidate list with sorted insertion.
// Latency: a result appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless rsp_stall holds the result; all list slots are
// compared in parallel against the candidate and the shift completes in the accept cycle.
// Reset (synchronous, active high) empties the result register, sets list_length to 16,
// all ids to zero and all distances to the maximum value.
module k_nearest_list_insert_core
   import knl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [ID_W-1:0]   req_candidate_id,
   input  logic [DIST_W-1:0] req_candidate_distance,
   input  logic [POS_W-1:0]  req_slot,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ID_W-1:0]   rsp_out_id,
   output logic [DIST_W-1:0] rsp_out_distance,
   output logic [POS_W-1:0]  rsp_insert_position,
   output logic [DIST_W-1:0] rsp_worst_distance
);

   // The controller only decides when an item executes; the datapath holds
   // the list, computes the insertion in one step and captures the result.
   ctrl_cmd_type cmd;

   knl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // An insert always evicts slot 0; entries above it slide down while they
   // are strictly farther than the candidate, so equal distances stay above.
   knl_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_kind               (req_kind),
      .req_candidate_id       (req_candidate_id),
      .req_candidate_distance (req_candidate_distance),
      .req_slot               (req_slot),
      .rsp_out_id             (rsp_out_id),
      .rsp_out_distance       (rsp_out_distance),
      .rsp_insert_position    (rsp_insert_position),
      .rsp_worst_distance     (rsp_worst_distance)
   );

   // An accepted item always leaves a result in the next cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item produced no result");

   // The input side is only held back by a result that is itself held back.
   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   // After an insert, slot 0 is either the candidate or an entry farther away.
   a_worst_not_below_candidate: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == KIND_INSERT)
      |=> (rsp_worst_distance >= $past(req_candidate_distance)))
      else $error("worst distance below inserted candidate");

   // An insert into slot 0 reports the candidate itself as the new worst.
   a_slot0_insert_worst: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == KIND_INSERT)
      ##1 (rsp_insert_position == '0)
      |-> (rsp_worst_distance == $past(req_candidate_distance)))
      else $error("slot 0 insert reported wrong worst distance");

endmodule

FILE: bench/tb_k_nearest_list_insert_core.sv
// Self-checking testbench for the k-nearest candidate list with sorted insertion.
`timescale 1ns / 1ps

module tb_k_nearest_list_insert_core;
   import knl_pkg::*;

   // The run is stopped as failed if it has not finished within this many cycles.
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] distance;
      logic [POS_W-1:0]  slot;
   } list_item_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] distance;
      logic [POS_W-1:0]  position;
      logic [DIST_W-1:0] worst;
   } list_result_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [LEN_W-1:0]  csr_wr_data;
   logic              req_valid;
   logic              req_stall;
   logic              req_kind;
   logic [ID_W-1:0]   req_candidate_id;
   logic [DIST_W-1:0] req_candidate_distance;
   logic [POS_W-1:0]  req_slot;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [ID_W-1:0]   rsp_out_id;
   logic [DIST_W-1:0] rsp_out_distance;
   logic [POS_W-1:0]  rsp_insert_position;
   logic [DIST_W-1:0] rsp_worst_distance;

   k_nearest_list_insert_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_candidate_id       (req_candidate_id),
      .req_candidate_distance (req_candidate_distance),
      .req_slot               (req_slot),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_out_id             (rsp_out_id),
      .rsp_out_distance       (rsp_out_distance),
      .rsp_insert_position    (rsp_insert_position),
      .rsp_worst_distance     (rsp_worst_distance)
   );

   // Mirror of the candidate list and its length register, kept in step with every
   // item the block accepts and every register write it sees.
   logic [ID_W-1:0]   mirror_ids   [MAX_SLOTS];
   logic [DIST_W-1:0] mirror_dists [MAX_SLOTS];
   logic [LEN_W-1:0]  mirror_length;

   list_item_type   pending_items [$];   // Items waiting for the driver.
   list_result_type due_results   [$];   // Predicted results, oldest first.

   int  items_queued;
   int  items_taken;
   int  error_count;
   int  cycle_count;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_sender;
   bit  req_taken;              // The item on the request port was accepted.
   logic [DIST_W-1:0] run_distance;  // Falling distance used for well-formed runs.
   logic [DIST_W-1:0] last_distance;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Predicts the result of one item and updates the mirror. An insert always
   // evicts slot 0; entries above it slide down while their distance is strictly
   // greater than the candidate's, so the candidate settles below equal distances.
   function automatic list_result_type apply_list_item(input list_item_type item);
      list_result_type res;
      int              k;
      int              pos;
      k = int'(mirror_length);
      if (k < 1) k = 1;
      if (k > MAX_SLOTS) k = MAX_SLOTS;
      if (item.kind == KIND_INSERT) begin
         res.id       = mirror_ids[0];
         res.distance = mirror_dists[0];
         pos = 0;
         while (pos + 1 < k && mirror_dists[pos + 1] > item.distance) begin
            mirror_ids[pos]   = mirror_ids[pos + 1];
            mirror_dists[pos] = mirror_dists[pos + 1];
            pos++;
         end
         mirror_ids[pos]   = item.id;
         mirror_dists[pos] = item.distance;
         res.position      = POS_W'(pos);
      end else begin
         // Slots past the store would read as zero; with a 4-bit slot and 16
         // entries every slot lands inside the store.
         res.id       = '0;
         res.distance = '0;
         if (int'(item.slot) < MAX_SLOTS) begin
            res.id       = mirror_ids[item.slot];
            res.distance = mirror_dists[item.slot];
         end
         res.position = item.slot;
      end
      res.worst = mirror_dists[0];
      return res;
   endfunction

   function automatic list_item_type insert_item(input logic [ID_W-1:0] id,
                                                 input logic [DIST_W-1:0] distance);
      list_item_type item;
      item.kind     = KIND_INSERT;
      item.id       = id;
      item.distance = distance;
      item.slot     = POS_W'($urandom);
      return item;
   endfunction

   function automatic list_item_type read_item(input logic [POS_W-1:0] slot);
      list_item_type item;
      item.kind     = KIND_READ;
      item.id       = ID_W'($urandom);
      item.distance = $urandom;
      item.slot     = slot;
      return item;
   endfunction

   // Random traffic: mostly inserts, many of them in falling-distance runs so that
   // each candidate beats the ones before it, mixed with ties, extremes and reads.
   function automatic list_item_type random_list_item();
      int          pick;
      logic [DIST_W-1:0] distance;
      if ($urandom_range(99) < 30) return read_item(POS_W'($urandom_range(0, 15)));
      pick = $urandom_range(9);
      case (pick)
         0, 1, 2, 3: begin
            if (run_distance < 32'h0010_0000) run_distance = $urandom;
            run_distance = run_distance - $urandom_range(1, 32'h0010_0000);
            distance = run_distance;
         end
         4, 5: distance = $urandom_range(0, 15);
         6, 7: distance = $urandom;
         8: distance = ($urandom_range(1) == 1) ? '1 : '0;
         default: distance = last_distance;
      endcase
      last_distance = distance;
      return insert_item(ID_W'($urandom), distance);
   endfunction

   task automatic queue_item(input list_item_type item);
      pending_items.push_back(item);
      items_queued++;
   endtask

   task automatic report_mismatch(input string what, input logic [DIST_W-1:0] got,
                                  input logic [DIST_W-1:0] want);
      error_count++;
      $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
   endtask

   // Returns at a falling edge once every queued item has been taken and every
   // predicted result has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (items_taken != items_queued || due_results.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   // Called at a falling edge with the block idle.
   task automatic write_list_length(input logic [LEN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= LEN_W'($urandom);
   endtask

   // Queues a batch of random items; with a pause the sender stops halfway and
   // waits until every outstanding result has come before going on.
   task automatic run_batch(input int count, input bit with_pause);
      @(posedge clock);
      repeat (count) queue_item(random_list_item());
      if (with_pause) begin
         do @(negedge clock);
         while (items_taken < items_queued - count / 2);
         hold_sender <= 1'b1;
         do @(negedge clock);
         while (items_taken + pending_items.size() != items_queued
                || due_results.size() != 0);
         hold_sender <= 1'b0;
      end
      wait_drained();
   endtask

   // Driver: presents the next pending item at the falling edge and holds it
   // until the block takes it. The sender idles at random or while held off.
   always @(negedge clock) begin : request_driver
      list_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // A stalled item stays on the port unchanged.
      end else begin
         req_taken = 1'b0;
         if (hold_sender || pending_items.size() == 0
             || $urandom_range(99) < send_idle_pct) begin
            req_valid              <= 1'b0;
            req_kind               <= 1'($urandom);
            req_candidate_id       <= ID_W'($urandom);
            req_candidate_distance <= $urandom;
            req_slot               <= POS_W'($urandom);
         end else begin
            item = pending_items.pop_front();
            req_valid              <= 1'b1;
            req_kind               <= item.kind;
            req_candidate_id       <= item.id;
            req_candidate_distance <= item.distance;
            req_slot               <= item.slot;
         end
      end
   end

   // The receiver stalls at random, also at the falling edge.
   always @(negedge clock) begin : response_stall
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Monitor: at each rising edge, first checks a result that is taken, then
   // predicts for an item that is taken, then follows a register write. A result
   // can never belong to an item taken at the same edge, so this order is safe.
   always @(posedge clock) begin : list_monitor
      list_result_type got;
      list_result_type want;
      list_item_type   item;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_id, rsp_out_distance, rsp_insert_position, rsp_worst_distance};
            if (due_results.size() == 0) begin
               report_mismatch("result with no item outstanding", '0, '0);
            end else begin
               want = due_results.pop_front();
               if (got.id != want.id)
                  report_mismatch("out_id", DIST_W'(got.id), DIST_W'(want.id));
               if (got.distance != want.distance)
                  report_mismatch("out_distance", got.distance, want.distance);
               if (got.position != want.position)
                  report_mismatch("insert_position", DIST_W'(got.position),
                                  DIST_W'(want.position));
               if (got.worst != want.worst)
                  report_mismatch("worst_distance", got.worst, want.worst);
            end
         end
         if (req_valid && !req_stall) begin
            item = '{req_kind, req_candidate_id, req_candidate_distance, req_slot};
            due_results.push_back(apply_list_item(item));
            items_taken++;
            req_taken = 1'b1;
         end
         if (csr_wr_en) mirror_length = csr_wr_data;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Test sequence: reset, a directed pass through the extremes and the special
   // cases of the list length, then random batches under several list lengths.
   initial begin : sequence_main
      int lengths [12];
      int counts  [12];
      lengths = '{16, 1, 2, 31, 8, 0, 5, 16, 3, 17, 12, 16};
      counts  = '{200, 100, 100, 150, 150, 100, 150, 200, 150, 100, 150, 200};

      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      req_valid              = 1'b0;
      req_kind               = KIND_INSERT;
      req_candidate_id       = '0;
      req_candidate_distance = '0;
      req_slot               = '0;
      rsp_stall              = 1'b0;
      req_taken              = 1'b0;
      hold_sender            = 1'b0;
      items_queued           = 0;
      items_taken            = 0;
      error_count            = 0;
      cycle_count            = 0;
      send_idle_pct          = 10;
      recv_idle_pct          = 47;
      run_distance           = '1;
      last_distance          = '0;
      mirror_length          = LIST_LENGTH_RESET;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         mirror_ids[i]   = '0;
         mirror_dists[i] = '1;
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset length of 16. The empty list reads as all
      // maximum distances; a zero distance sinks to the top slot, a maximum
      // distance stays in slot 0, and equal distances land below each other.
      @(posedge clock);
      queue_item(read_item(4'd0));
      queue_item(read_item(4'd15));
      queue_item(insert_item(24'hFF_FFFF, 32'h0000_0000));
      queue_item(insert_item(24'h00_0000, 32'hFFFF_FFFF));
      queue_item(insert_item(24'h12_3456, 32'h0001_0000));
      queue_item(insert_item(24'h65_4321, 32'h0001_0000));
      queue_item(insert_item(24'h00_0005, 32'hFFFF_FFFE));
      queue_item(insert_item(24'h00_0001, 32'hAAAA_AAAA));
      queue_item(insert_item(24'h80_0000, 32'h5555_5555));
      queue_item(read_item(4'd15));
      queue_item(read_item(4'd14));
      queue_item(read_item(4'd13));
      wait_drained();

      // A length of zero acts as one: every insert lands in slot 0, while the
      // entries beyond it are kept and can still be read.
      write_list_length(5'd0);
      @(posedge clock);
      queue_item(insert_item(24'h00_002A, 32'h0000_0007));
      queue_item(read_item(4'd5));
      queue_item(read_item(4'd15));
      wait_drained();

      // A length above the store size acts as the full store.
      write_list_length(5'd31);
      @(posedge clock);
      queue_item(insert_item(24'hFF_FFFF, 32'h0000_0001));
      queue_item(read_item(4'd0));
      wait_drained();

      write_list_length(5'd1);
      @(posedge clock);
      queue_item(insert_item(24'h0F_0F0F, 32'hFFFF_FFFF));
      wait_drained();

      // Back to the full length mid-stream; the entries left behind take part again.
      write_list_length(5'd16);
      @(posedge clock);
      queue_item(insert_item(24'hF0_F0F0, 32'h0000_0000));
      queue_item(read_item(4'd15));
      queue_item(read_item(4'd14));
      wait_drained();

      // Random part: sender idles lightly and receiver heavily first, then the
      // reverse, then neither idles.
      for (int i = 0; i < 12; i++) begin
         if (i == 4) begin
            send_idle_pct <= 47;
            recv_idle_pct <= 10;
         end else if (i == 8) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         write_list_length(LEN_W'(lengths[i]));
         run_batch(counts[i], (i % 4) == 0);
      end

      repeat (4) @(negedge clock);
      if (error_count == 0 && due_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/knl_pkg.sv
hdl/knl_ctrl.sv
hdl/knl_datapath.sv
hdl/k_nearest_list_insert_core.sv
bench/tb_k_nearest_list_insert_core.sv
